FILE: rtl/gww_pkg.sv
// Shared types, constants and helpers for the greedy word wrap unit.
package gww_pkg;

   // Sizes and limits
   localparam int MaxLineDef = 60;
   localparam int LenW       = 6;
   localparam int ChW        = 8;
   localparam int MaxResults = 63;
   localparam int Indent     = 3;
   localparam int MinWidth   = 4;
   localparam int WidthReset = 60;

   // Character codes
   localparam logic [ChW-1:0] CharTab   = 8'd9;
   localparam logic [ChW-1:0] CharNl    = 8'd10;
   localparam logic [ChW-1:0] CharSpace = 8'h20;
   localparam logic [ChW-1:0] CharLowA  = 8'h61;
   localparam logic [ChW-1:0] CharLowZ  = 8'h7a;
   localparam logic [ChW-1:0] CharUpA   = 8'h41;
   localparam logic [ChW-1:0] CharUpZ   = 8'h5a;

   // Sequencer states; also select what goes into the result register
   typedef enum logic [2:0] {
      S_IDLE,
      S_TAB,
      S_NL1,
      S_WORD,
      S_NL2,
      S_CHR,
      S_ERR
   } state_type;

   // Which results one request produces
   typedef struct packed {
      logic tab;
      logic nl1;
      logic word;
      logic nl2;
      logic chr;
      logic err;
   } plan_type;

   // Datapath to controller
   typedef struct packed {
      logic     accepted;
      logic     out_free;
      logic     word_last;
      logic     halted;
      plan_type plan_new;
      plan_type plan;
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic      take;
      logic      emit;
      logic      last;
      state_type sel;
   } cmd_type;

   function automatic logic is_letter(input logic [ChW-1:0] c);
      return (c >= CharLowA && c <= CharLowZ) || (c >= CharUpA && c <= CharUpZ);
   endfunction

endpackage

FILE: rtl/gww_if.sv
// Valid/ready channel interfaces for requests, results and the width register.
interface gww_req_if import gww_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [ChW-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface gww_rsp_if import gww_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [ChW-1:0] out_char;
   logic           is_error;
   logic           last;

   modport source (output valid, output out_char, output is_error, output last, input ready);
   modport sink   (input valid, input out_char, input is_error, input last, output ready);
endinterface

interface gww_csr_if import gww_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [LenW-1:0] line_width;

   modport source (output valid, output line_width, input ready);
   modport sink   (input valid, input line_width, output ready);
endinterface

FILE: rtl/gww_ctrl.sv
// Sequencer that steps through the results of one request.
module gww_ctrl import gww_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type stat,
   output cmd_type    cmd
);

   localparam int CntW = $clog2(MaxResults + 1);

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            more;
   logic            last;
   logic            emit;

   // First pending result among the later kinds
   function automatic state_type first_of(input logic nl1, input logic word,
                                          input logic nl2, input logic chr);
      if (nl1)       return S_NL1;
      else if (word) return S_WORD;
      else if (nl2)  return S_NL2;
      else if (chr)  return S_CHR;
      else           return S_IDLE;
   endfunction

   // Outputs
   always_comb begin
      unique case (state_ff)
         S_TAB:   more = stat.plan.nl1 | stat.plan.word | stat.plan.nl2 | stat.plan.chr;
         S_NL1:   more = stat.plan.word | stat.plan.nl2 | stat.plan.chr;
         S_WORD:  more = !stat.word_last | stat.plan.nl2 | stat.plan.chr;
         S_NL2:   more = stat.plan.chr;
         default: more = 1'b0;
      endcase
      // result overflow: the last one allowed closes the request
      last     = !more || (cnt_ff == CntW'(MaxResults - 1));
      emit     = (state_ff != S_IDLE) && stat.out_free;
      cmd.take = (state_ff == S_IDLE);
      cmd.emit = emit;
      cmd.last = last;
      cmd.sel  = state_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (stat.accepted) begin
               if (stat.plan_new.err)      state_in = S_ERR;
               else if (stat.plan_new.tab) state_in = S_TAB;
               else state_in = first_of(stat.plan_new.nl1, stat.plan_new.word,
                                        stat.plan_new.nl2, stat.plan_new.chr);
            end
         end
         S_TAB: begin
            if (emit) state_in = last ? S_IDLE :
               first_of(stat.plan.nl1, stat.plan.word, stat.plan.nl2, stat.plan.chr);
         end
         S_NL1: begin
            if (emit) state_in = last ? S_IDLE :
               first_of(1'b0, stat.plan.word, stat.plan.nl2, stat.plan.chr);
         end
         S_WORD: begin
            if (emit) begin
               if (last)                 state_in = S_IDLE;
               else if (!stat.word_last) state_in = S_WORD;
               else state_in = first_of(1'b0, 1'b0, stat.plan.nl2, stat.plan.chr);
            end
         end
         S_NL2: begin
            if (emit) state_in = last ? S_IDLE : S_CHR;
         end
         S_CHR, S_ERR: begin
            if (emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result counter per request
   always_comb begin
      cnt_in = cnt_ff;
      if (stat.accepted) cnt_in = '0;
      else if (emit)     cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/gww_dp.sv
// Datapath: line state, word buffer memory, width register and result register.
module gww_dp import gww_pkg::*; #(
   parameter int MaxLine = MaxLineDef
) (
   input  logic          clock,
   input  logic          reset,
   gww_req_if.sink       req,
   gww_rsp_if.source     rsp,
   gww_csr_if.sink       csr,
   input  cmd_type       cmd,
   output status_type    stat
);

   localparam int AddrW = $clog2(MaxLine);
   localparam logic [LenW-1:0] MaxLen = LenW'(MaxLine);

   // Architectural state
   logic [LenW-1:0] lw_ff;
   logic            started_ff, started_in;
   logic            halted_ff, halted_in;
   logic            prev_ff, prev_in;
   logic [LenW-1:0] wl_ff, wl_in;
   logic [LenW-1:0] col_ff, col_in;

   // Per-request emission state
   plan_type        plan_ff;
   logic [ChW-1:0]  ch_ff;
   logic [LenW-1:0] emit_len_ff;
   logic [LenW-1:0] idx_ff, idx_in;

   // Word buffer
   logic [ChW-1:0]  mem [MaxLine];
   logic [ChW-1:0]  rd_data_ff;

   // Result register
   logic            rsp_valid_ff;
   logic [ChW-1:0]  out_char_ff;
   logic            is_error_ff;
   logic            last_ff;

   logic            acc, skip, letter, is_space, err, wrap, fit;
   logic [LenW-1:0] w, base, col_a, col_fin;
   logic [LenW:0]   sum;
   plan_type        plan_new;

   assign csr.ready = 1'b1;
   assign req.ready = cmd.take;

   // Effective line width, saturated into the legal range
   always_comb begin
      if (lw_ff < LenW'(MinWidth)) w = LenW'(MinWidth);
      else if (lw_ff > MaxLen)     w = MaxLen;
      else                         w = lw_ff;
   end

   // Decode the incoming request and its column arithmetic
   always_comb begin
      acc      = cmd.take && req.valid;
      skip     = halted_ff || (req.ch == CharNl);
      letter   = is_letter(req.ch);
      is_space = (req.ch == CharSpace);
      base     = started_ff ? col_ff : LenW'(Indent);
      err      = prev_ff && (wl_ff > w);
      sum      = {1'b0, base} + {1'b0, wl_ff};
      wrap     = prev_ff && (sum > {1'b0, w});
      if (!prev_ff)  col_a = base;
      else if (wrap) col_a = wl_ff;
      else           col_a = sum[LenW-1:0];
      fit      = col_a < w;
      if (fit)           col_fin = col_a + 1'b1;
      else if (is_space) col_fin = col_a;
      else               col_fin = LenW'(1);
   end

   // Results this request will produce
   always_comb begin
      plan_new = '0;
      if (!skip) begin
         plan_new.tab = !started_ff;
         if (!letter) begin
            if (err) begin
               plan_new.tab = 1'b0;
               plan_new.err = 1'b1;
            end else begin
               plan_new.nl1  = wrap;
               plan_new.word = prev_ff;
               plan_new.nl2  = !fit && !is_space;
               plan_new.chr  = fit || !is_space;
            end
         end
      end
   end

   // Next line state on an accepted request
   always_comb begin
      started_in = started_ff;
      halted_in  = halted_ff;
      prev_in    = prev_ff;
      wl_in      = wl_ff;
      col_in     = col_ff;
      if (acc && !skip) begin
         started_in = 1'b1;
         if (letter) begin
            if (wl_ff <= MaxLen) wl_in = wl_ff + 1'b1;
            prev_in = 1'b1;
            col_in  = base;
         end else if (err) begin
            halted_in = 1'b1;
            wl_in     = '0;
            prev_in   = 1'b0;
         end else begin
            col_in  = col_fin;
            wl_in   = '0;
            prev_in = 1'b0;
         end
      end
   end

   // Word index; read address runs one ahead while the word goes out
   always_comb begin
      idx_in = idx_ff;
      if (acc)                               idx_in = '0;
      else if (cmd.emit && cmd.sel == S_WORD) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff      <= LenW'(WidthReset);
         started_ff <= 1'b0;
         halted_ff  <= 1'b0;
         prev_ff    <= 1'b0;
         wl_ff      <= '0;
         col_ff     <= '0;
         plan_ff    <= '0;
      end else begin
         if (csr.valid) lw_ff <= csr.line_width;
         started_ff <= started_in;
         halted_ff  <= halted_in;
         prev_ff    <= prev_in;
         wl_ff      <= wl_in;
         col_ff     <= col_in;
         if (acc) plan_ff <= plan_new;
      end
   end

   // Request payload kept for the emission sequence
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (acc) begin
         ch_ff       <= req.ch;
         emit_len_ff <= wl_ff;
      end
   end

   // Word buffer memory
   always_ff @(posedge clock) begin
      if (acc && !skip && letter && wl_ff < MaxLen) mem[wl_ff[AddrW-1:0]] <= req.ch;
   end

   always_ff @(posedge clock) begin
      if (idx_in < MaxLen) rd_data_ff <= mem[idx_in[AddrW-1:0]];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         unique case (cmd.sel)
            S_TAB:         out_char_ff <= CharTab;
            S_NL1, S_NL2:  out_char_ff <= CharNl;
            S_WORD:        out_char_ff <= rd_data_ff;
            S_CHR:         out_char_ff <= ch_ff;
            default:       out_char_ff <= '0;
         endcase
         is_error_ff <= (cmd.sel == S_ERR);
         last_ff     <= cmd.last;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = out_char_ff;
   assign rsp.is_error = is_error_ff;
   assign rsp.last     = last_ff;

   // Status to the sequencer
   always_comb begin
      stat.accepted  = acc;
      stat.out_free  = !rsp_valid_ff || rsp.ready;
      stat.word_last = (idx_ff + 1'b1) == emit_len_ff;
      stat.halted    = halted_ff;
      stat.plan_new  = plan_new;
      stat.plan      = plan_ff;
   end

endmodule

FILE: rtl/greedy_word_wrap_unit.sv
// Greedy word wrap: wraps a byte stream into lines of at most line_width (4..MaxLine) columns.
// A letter gives no result (the first byte that is not a newline adds a tab).
// A word end gives one result per cycle while the output is free: optional newline, the
// buffered word from the word memory one byte a cycle, optional newline, optional character.
// The next request is taken as soon as the last result is in the output register.
// Reset is synchronous: line state clears, line_width returns to 60, word memory is not cleared.
module greedy_word_wrap_unit import gww_pkg::*; #(
   parameter int MaxLine = MaxLineDef
) (
   input  logic      clock,
   input  logic      reset,
   gww_req_if.sink   req,
   gww_rsp_if.source rsp,
   gww_csr_if.sink   csr
);

   cmd_type    cmd;
   status_type stat;

   gww_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   gww_dp #(.MaxLine(MaxLine)) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .stat  (stat)
   );

   // An error result is alone and carries a zero byte
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_error |-> rsp.last && rsp.out_char == '0)
      else $error("error result not final");

   // A newline request produces nothing
   a_nl_quiet: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.ch == CharNl |=> cmd.sel == S_IDLE)
      else $error("newline request started a sequence");

   // A halted block plans no results
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      stat.halted |-> stat.plan_new == '0)
      else $error("halted block planned results");

endmodule
